### rtl/core/hieq_pkg.sv
// Package for the 8-bit histogram equalization unit.
// Holds widths, limits and the divider request/response structs.
// No dependencies.
`timescale 1ns / 1ps

package hieq_pkg;

  localparam int unsigned COUNT_BITS = 25;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned NUM_BINS   = 256;
  localparam int unsigned NUM_W      = COUNT_BITS + PIX_W;
  localparam int unsigned DIV_STEPS  = PIX_W + 1;
  localparam int unsigned STEP_W     = $clog2(DIV_STEPS);

  localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = {COUNT_BITS{1'b1}};
  localparam logic [PIX_W-1:0]      MAX_LEVEL   = {PIX_W{1'b1}};
  localparam logic [PIX_W-1:0]      LAST_BIN    = PIX_W'(NUM_BINS - 1);

  localparam logic REQ_COUNT = 1'b0;
  localparam logic REQ_MAP   = 1'b1;

  typedef struct packed {
    logic                  start;
    logic [NUM_W-1:0]      numer;
    logic [COUNT_BITS-1:0] denom;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [PIX_W-1:0] quot;
  } div_rsp_t;

endpackage

### rtl/core/hieq_if.sv
// Valid/ready channel interfaces for pixel requests and mapped results.
// Depends on hieq_pkg.
`timescale 1ns / 1ps

interface hieq_in_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [hieq_pkg::PIX_W-1:0] pixel;
  logic                       last_pixel;

  modport source (output valid, output req_type, output pixel, output last_pixel,
                  input ready);
  modport sink   (input valid, input req_type, input pixel, input last_pixel,
                  output ready);
endinterface

interface hieq_out_if;
  logic                       valid;
  logic                       ready;
  logic [hieq_pkg::PIX_W-1:0] mapped_pixel;
  logic                       count_saturated;

  modport source (output valid, output mapped_pixel, output count_saturated,
                  input ready);
  modport sink   (input valid, input mapped_pixel, input count_saturated,
                  output ready);
endinterface

### rtl/core/hieq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module hieq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/core/hieq_div.sv
// Iterative restoring divider, one quotient bit per cycle, saturating at 255.
// Depends on hieq_pkg.
`timescale 1ns / 1ps

module hieq_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hieq_pkg::div_req_t req_i,
  output hieq_pkg::div_rsp_t rsp_o
);

  logic [hieq_pkg::NUM_W-1:0]  rem_q, rem_d;
  logic [hieq_pkg::NUM_W-1:0]  den_q, den_d;
  logic [hieq_pkg::PIX_W:0]    quot_q, quot_d;
  logic [hieq_pkg::STEP_W-1:0] cnt_q, cnt_d;
  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic                        ge;

  assign ge = (rem_q >= den_q);

  always_comb begin
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = req_i.numer;
      den_d  = {req_i.denom, hieq_pkg::PIX_W'(0)};
      cnt_d  = hieq_pkg::STEP_W'(hieq_pkg::DIV_STEPS - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (ge) begin
        rem_d = rem_q - den_q;
      end
      den_d  = den_q >> 1;
      quot_d = {quot_q[hieq_pkg::PIX_W-1:0], ge};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  // top quotient bit set means the result is 256 or more
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q[hieq_pkg::PIX_W] ? hieq_pkg::MAX_LEVEL
                                              : quot_q[hieq_pkg::PIX_W-1:0];

endmodule

### rtl/core/histogram_equalization_8bit_unit.sv
// Top level of the 8-bit histogram equalization unit: sequencer, histogram
// and table RAMs. Depends on hieq_pkg, hieq_if, hieq_ram and hieq_div.
//
//   channel | dir | fields                                  | role
//   in_i    | in  | req_type, pixel, last_pixel             | count or map request
//   out_o   | out | mapped_pixel, count_saturated           | result item
//
// A count item steps through accept, bin read and bin write; a map item steps
// through accept, table read and output load. A last count item then builds
// the table, per bin: read, accumulate, numerator, then the 9-step shared
// divider, which is skipped when the count is 0 or 1; a status item follows.
// Reset clears bin valid bits, the count and the flag; no clearing sweep.
// A full output register stalls the sequencer only where it emits an item.
`timescale 1ns / 1ps

module histogram_equalization_8bit_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  hieq_in_if.sink    in_i,
  hieq_out_if.source out_o
);

  localparam int unsigned CW = hieq_pkg::COUNT_BITS;
  localparam int unsigned PW = hieq_pkg::PIX_W;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CNT_RD  = 4'd1;
  localparam logic [3:0] S_CNT_WR  = 4'd2;
  localparam logic [3:0] S_B_RD    = 4'd3;
  localparam logic [3:0] S_B_ACC   = 4'd4;
  localparam logic [3:0] S_B_NUM   = 4'd5;
  localparam logic [3:0] S_B_DIV   = 4'd6;
  localparam logic [3:0] S_STAT    = 4'd7;
  localparam logic [3:0] S_MAP_RD  = 4'd8;
  localparam logic [3:0] S_MAP_OUT = 4'd9;

  logic [3:0]    state_q, state_d;
  logic [PW-1:0] pix_q, pix_d;
  logic          last_q, last_d;
  logic [CW-1:0] seen_q, seen_d;
  logic          sat_q, sat_d;
  logic          tbl_vld_q, tbl_vld_d;
  logic [hieq_pkg::NUM_BINS-1:0] bin_vld_q, bin_vld_d;
  logic [PW-1:0] idx_q, idx_d;
  logic [CW-1:0] run_q, run_d;
  logic [CW-1:0] base_q, base_d;

  logic          out_vld_q, out_vld_d;
  logic [PW-1:0] out_pix_q, out_pix_d;
  logic          out_sat_q, out_sat_d;

  logic          in_fire, out_free, tiny;
  logic          bin_we, tbl_we;
  logic [PW-1:0] bin_raddr, tbl_wdata;
  logic [CW-1:0] bin_rdata, bin_eff, bin_sum, diff;
  logic [PW-1:0] tbl_rdata;

  hieq_pkg::div_req_t div_req;
  hieq_pkg::div_rsp_t div_rsp;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !out_vld_q || out_o.ready;
  assign tiny       = (seen_q[CW-1:1] == '0);

  assign bin_raddr = (state_q == S_CNT_RD) ? pix_q : idx_q;
  assign bin_eff   = (state_q == S_CNT_WR) ? (bin_vld_q[pix_q] ? bin_rdata : '0)
                                           : (bin_vld_q[idx_q] ? bin_rdata : '0);
  assign bin_sum   = run_q + bin_eff;
  assign diff      = run_q - base_q;

  assign bin_we    = (state_q == S_CNT_WR);
  assign tbl_we    = ((state_q == S_B_NUM) && tiny) ||
                     ((state_q == S_B_DIV) && div_rsp.done);
  assign tbl_wdata = (state_q == S_B_NUM) ? '0 : div_rsp.quot;

  // numerator (cdf - cdf0) * 255 as shift and subtract
  assign div_req.start = (state_q == S_B_NUM) && !tiny;
  assign div_req.numer = {diff, PW'(0)} - {PW'(0), diff};
  assign div_req.denom = seen_q - 1'b1;

  hieq_ram #(.Width(CW), .Depth(hieq_pkg::NUM_BINS)) u_bin_ram (
    .clk_i   (clk_i),
    .we_i    (bin_we),
    .waddr_i (pix_q),
    .wdata_i (bin_eff + 1'b1),
    .raddr_i (bin_raddr),
    .rdata_o (bin_rdata)
  );

  hieq_ram #(.Width(PW), .Depth(hieq_pkg::NUM_BINS)) u_tbl_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (idx_q),
    .wdata_i (tbl_wdata),
    .raddr_i (pix_q),
    .rdata_o (tbl_rdata)
  );

  hieq_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d   = state_q;
    pix_d     = pix_q;
    last_d    = last_q;
    seen_d    = seen_q;
    sat_d     = sat_q;
    tbl_vld_d = tbl_vld_q;
    bin_vld_d = bin_vld_q;
    idx_d     = idx_q;
    run_d     = run_q;
    base_d    = base_q;
    out_vld_d = out_vld_q && !out_o.ready;
    out_pix_d = out_pix_q;
    out_sat_d = out_sat_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          pix_d  = in_i.pixel;
          last_d = in_i.last_pixel;
          if (in_i.req_type == hieq_pkg::REQ_MAP) begin
            state_d = S_MAP_RD;
          end else if (seen_q != hieq_pkg::COUNT_LIMIT) begin
            state_d = S_CNT_RD;
          end else begin
            sat_d = 1'b1;
            if (in_i.last_pixel) begin
              idx_d     = '0;
              run_d     = '0;
              tbl_vld_d = 1'b1;
              state_d   = S_B_RD;
            end
          end
        end
      end
      S_CNT_RD: begin
        state_d = S_CNT_WR;
      end
      S_CNT_WR: begin
        bin_vld_d[pix_q] = 1'b1;
        seen_d           = seen_q + 1'b1;
        if (last_q) begin
          idx_d     = '0;
          run_d     = '0;
          tbl_vld_d = 1'b1;
          state_d   = S_B_RD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_B_RD: begin
        state_d = S_B_ACC;
      end
      S_B_ACC: begin
        run_d = bin_sum;
        if (idx_q == '0) begin
          base_d = bin_sum;
        end
        state_d = S_B_NUM;
      end
      S_B_NUM: begin
        if (tiny) begin
          idx_d   = idx_q + 1'b1;
          state_d = (idx_q == hieq_pkg::LAST_BIN) ? S_STAT : S_B_RD;
        end else begin
          state_d = S_B_DIV;
        end
      end
      S_B_DIV: begin
        if (div_rsp.done) begin
          idx_d   = idx_q + 1'b1;
          state_d = (idx_q == hieq_pkg::LAST_BIN) ? S_STAT : S_B_RD;
        end
      end
      S_STAT: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          out_pix_d = '0;
          out_sat_d = sat_q;
          state_d   = S_IDLE;
        end
      end
      S_MAP_RD: begin
        state_d = S_MAP_OUT;
      end
      S_MAP_OUT: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          out_pix_d = tbl_vld_q ? tbl_rdata : '0;
          out_sat_d = sat_q;
          state_d   = S_IDLE;
          if (last_q) begin
            bin_vld_d = '0;
            seen_d    = '0;
            sat_d     = 1'b0;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      seen_q    <= '0;
      sat_q     <= 1'b0;
      tbl_vld_q <= 1'b0;
      bin_vld_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      seen_q    <= seen_d;
      sat_q     <= sat_d;
      tbl_vld_q <= tbl_vld_d;
      bin_vld_q <= bin_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q     <= pix_d;
    last_q    <= last_d;
    idx_q     <= idx_d;
    run_q     <= run_d;
    base_q    <= base_d;
    out_pix_q <= out_pix_d;
    out_sat_q <= out_sat_d;
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.mapped_pixel    = out_pix_q;
  assign out_o.count_saturated = out_sat_q;

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> ($past(state_q) == S_STAT) || ($past(state_q) == S_MAP_OUT))
    else $error("result item raised outside an emitting state");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_B_DIV))
    else $error("divider finished outside a table build step");

  a_map_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_MAP_OUT) && out_free && last_q) |=>
      (seen_q == '0) && !sat_q && (bin_vld_q == '0))
    else $error("histogram not cleared after last map item");

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_STAT) && out_free) |=> out_vld_q && (out_pix_q == '0))
    else $error("status item carries a nonzero pixel");

endmodule

### test/tb_histogram_equalization_8bit_unit.sv
// Testbench for histogram_equalization_8bit_unit: directed table, then random images.
// Results are compared in order against a local equalization predictor.
// Depends on hieq_pkg, hieq_if and the unit under test.
`timescale 1ns / 1ps

module tb_histogram_equalization_8bit_unit;

  localparam int unsigned NUM_DIRECTED = 22;
  localparam int unsigned RANDOM_ITEMS = 600;
  localparam int unsigned CYCLE_LIMIT  = 10_000_000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned PRESSURE_AT  = 40;
  localparam int unsigned PRESSURE_LEN = 600;

  typedef struct packed {
    logic [hieq_pkg::PIX_W-1:0] mapped;
    logic                       sat;
  } result_t;

  typedef struct packed {
    logic                       rq;
    logic [hieq_pkg::PIX_W-1:0] px;
    logic                       lst;
    logic                       typed;
    logic [hieq_pkg::PIX_W-1:0] val;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  hieq_in_if  pix_req ();
  hieq_out_if pix_rsp ();

  histogram_equalization_8bit_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (pix_req),
    .out_o  (pix_rsp)
  );

  logic [hieq_pkg::COUNT_BITS-1:0] hist_bins [hieq_pkg::NUM_BINS];
  logic [hieq_pkg::COUNT_BITS-1:0] pixel_total;
  logic                            hist_saturated;
  logic [hieq_pkg::PIX_W-1:0]      eq_table [hieq_pkg::NUM_BINS];

  result_t     pending_results [$];
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned error_cnt;
  int unsigned cycle_cnt;
  bit          src_burst;
  bit          snk_burst;

  // tiny image, repeated count pass, table lifetime, bin 0 empty (overflow)
  stim_row_t directed_rows [NUM_DIRECTED] = '{
    '{hieq_pkg::REQ_MAP,   8'd0,   1'b0, 1'b1, 8'd0},
    '{hieq_pkg::REQ_MAP,   8'd255, 1'b1, 1'b1, 8'd0},
    '{hieq_pkg::REQ_COUNT, 8'd255, 1'b1, 1'b1, 8'd0},
    '{hieq_pkg::REQ_MAP,   8'd255, 1'b0, 1'b1, 8'd0},
    '{hieq_pkg::REQ_MAP,   8'd128, 1'b1, 1'b1, 8'd0},
    '{hieq_pkg::REQ_COUNT, 8'd0,   1'b0, 1'b0, 8'd0},
    '{hieq_pkg::REQ_COUNT, 8'd0,   1'b0, 1'b0, 8'd0},
    '{hieq_pkg::REQ_COUNT, 8'd255, 1'b1, 1'b1, 8'd0},
    '{hieq_pkg::REQ_MAP,   8'd255, 1'b0, 1'b0, 8'd0},
    '{hieq_pkg::REQ_MAP,   8'd0,   1'b0, 1'b1, 8'd0},
    '{hieq_pkg::REQ_COUNT, 8'd85,  1'b0, 1'b0, 8'd0},
    '{hieq_pkg::REQ_COUNT, 8'd170, 1'b1, 1'b1, 8'd0},
    '{hieq_pkg::REQ_MAP,   8'd85,  1'b0, 1'b0, 8'd0},
    '{hieq_pkg::REQ_MAP,   8'd170, 1'b0, 1'b0, 8'd0},
    '{hieq_pkg::REQ_MAP,   8'd255, 1'b1, 1'b0, 8'd0},
    '{hieq_pkg::REQ_MAP,   8'd170, 1'b0, 1'b0, 8'd0},
    '{hieq_pkg::REQ_COUNT, 8'd255, 1'b0, 1'b0, 8'd0},
    '{hieq_pkg::REQ_COUNT, 8'd170, 1'b1, 1'b1, 8'd0},
    '{hieq_pkg::REQ_MAP,   8'd255, 1'b0, 1'b1, 8'd255},
    '{hieq_pkg::REQ_MAP,   8'd170, 1'b0, 1'b1, 8'd255},
    '{hieq_pkg::REQ_MAP,   8'd100, 1'b0, 1'b0, 8'd0},
    '{hieq_pkg::REQ_MAP,   8'd0,   1'b1, 1'b1, 8'd0}
  };

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  initial begin
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int unsigned pick_idle(inout bit burst);
    int unsigned r;
    if ($urandom_range(0, 99) < 2) burst = ~burst;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Equalization predictor; returns 1 when the item yields a result.
  function automatic bit equalize_step(input logic rq, input logic [hieq_pkg::PIX_W-1:0] px,
                                       input logic lst, output result_t res);
    longint unsigned running;
    longint unsigned base_cnt;
    longint unsigned quot;
    res = '0;
    if (rq == hieq_pkg::REQ_COUNT) begin
      if (pixel_total < hieq_pkg::COUNT_LIMIT) begin
        hist_bins[px] = hist_bins[px] + 1'b1;
        pixel_total   = pixel_total + 1'b1;
      end else begin
        hist_saturated = 1'b1;
      end
      if (!lst) return 1'b0;
      running  = 0;
      base_cnt = hist_bins[0];
      for (int v = 0; v < hieq_pkg::NUM_BINS; v++) begin
        if (pixel_total <= 1) begin
          eq_table[v] = '0;
        end else begin
          running += hist_bins[v];
          quot = ((running - base_cnt) * hieq_pkg::MAX_LEVEL) /
                 (longint'(pixel_total) - 1);
          eq_table[v] = (quot > hieq_pkg::MAX_LEVEL) ? hieq_pkg::MAX_LEVEL
                                                     : hieq_pkg::PIX_W'(quot);
        end
      end
      res.sat = hist_saturated;
      return 1'b1;
    end
    res.mapped = eq_table[px];
    res.sat    = hist_saturated;
    if (lst) begin
      for (int v = 0; v < hieq_pkg::NUM_BINS; v++) hist_bins[v] = '0;
      pixel_total    = '0;
      hist_saturated = 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic send_pixel(input logic rq, input logic [hieq_pkg::PIX_W-1:0] px,
                            input logic lst, input logic typed,
                            input logic [hieq_pkg::PIX_W-1:0] val);
    int unsigned gap;
    result_t     res;
    gap = pick_idle(src_burst);
    if (gap > 0) begin
      pix_req.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pix_req.valid      = 1'b1;
    pix_req.req_type   = rq;
    pix_req.pixel      = px;
    pix_req.last_pixel = lst;
    do @(posedge clk_i); while (pix_req.ready !== 1'b1);
    if (equalize_step(rq, px, lst, res)) begin
      if (typed) begin
        res.mapped = val;
        res.sat    = 1'b0;
      end
      pending_results.push_back(res);
    end
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_pass(input logic rq, input int unsigned len, input int unsigned lo,
                           input int unsigned hi, input int unsigned zero_pct);
    logic [hieq_pkg::PIX_W-1:0] px;
    for (int unsigned k = 0; k < len; k++) begin
      px = ($urandom_range(0, 99) < zero_pct) ? '0
                                              : hieq_pkg::PIX_W'($urandom_range(lo, hi));
      send_pixel(rq, px, k == len - 1, 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    int unsigned pick, lo, hi, zero_pct, len, r;
    pix_req.valid      = 1'b0;
    pix_req.req_type   = hieq_pkg::REQ_COUNT;
    pix_req.pixel      = '0;
    pix_req.last_pixel = 1'b0;
    for (int v = 0; v < hieq_pkg::NUM_BINS; v++) begin
      hist_bins[v] = '0;
      eq_table[v]  = '0;
    end
    pixel_total    = '0;
    hist_saturated = 1'b0;
    items_sent     = 0;
    src_burst      = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);

    for (int i = 0; i < NUM_DIRECTED; i++)
      send_pixel(directed_rows[i].rq, directed_rows[i].px, directed_rows[i].lst,
                 directed_rows[i].typed, directed_rows[i].val);

    while (items_sent < NUM_DIRECTED + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      lo   = $urandom_range(0, 255);
      hi   = $urandom_range(lo, 255);
      if ($urandom_range(0, 2) == 0) begin
        lo = 0;
        hi = 255;
      end
      zero_pct = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 60) : 0;
      r   = $urandom_range(0, 9);
      len = (r == 0) ? 1 : ((r == 9) ? $urandom_range(40, 80) : $urandom_range(2, 24));
      if (pick < 88) send_pass(hieq_pkg::REQ_COUNT, len, lo, hi, zero_pct);
      if (pick < 80) begin
        if ($urandom_range(0, 1) == 0) begin
          lo = 0;
          hi = 255;
        end
        send_pass(hieq_pkg::REQ_MAP, $urandom_range(1, 30), lo, hi, 0);
      end
      if (pick >= 88) begin
        // broken sequences: mixed requests, stray last flags
        len = $urandom_range(1, 6);
        for (int unsigned k = 0; k < len; k++)
          send_pixel(1'($urandom_range(0, 1)), hieq_pkg::PIX_W'($urandom_range(0, 255)),
                     $urandom_range(0, 4) == 0, 1'b0, '0);
      end
    end

    pix_req.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned hold;
    bit          pressure_done;
    hold          = 0;
    pressure_done = 1'b0;
    snk_burst     = 1'b0;
    pix_rsp.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (!pressure_done && results_seen >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        hold          = PRESSURE_LEN;
      end
      if (hold > 0) begin
        pix_rsp.ready = 1'b0;
        hold--;
      end else begin
        pix_rsp.ready = 1'b1;
        hold          = pick_idle(snk_burst);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pix_rsp.valid === 1'b1 && pix_rsp.ready === 1'b1) begin
      results_seen <= results_seen + 1;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, mapped_pixel %0d count_saturated %0b",
                 $time, pix_rsp.mapped_pixel, pix_rsp.count_saturated);
        error_cnt++;
      end else begin
        if (pix_rsp.mapped_pixel !== pending_results[0].mapped) begin
          $display("%0t: mapped_pixel expected %0d, got %0d",
                   $time, pending_results[0].mapped, pix_rsp.mapped_pixel);
          error_cnt++;
        end
        if (pix_rsp.count_saturated !== pending_results[0].sat) begin
          $display("%0t: count_saturated expected %0b, got %0b",
                   $time, pending_results[0].sat, pix_rsp.count_saturated);
          error_cnt++;
        end
        void'(pending_results.pop_front());
      end
    end
  end

endmodule

### filelist.f
rtl/core/hieq_pkg.sv
rtl/core/hieq_if.sv
rtl/core/hieq_ram.sv
rtl/core/hieq_div.sv
rtl/core/histogram_equalization_8bit_unit.sv
test/tb_histogram_equalization_8bit_unit.sv
